[rtl/core/sha1_pkg.sv]
// Shared types and constants for the streaming SHA-1 hasher.
package sha1_pkg;

    typedef logic [31:0] word_t;

    localparam int NUM_CHAIN   = 5;
    localparam int BLOCK_WORDS = 16;

    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [6:0] ROUND_MAJ     = 7'd40;
    localparam logic [6:0] ROUND_PAR1    = 7'd20;
    localparam logic [6:0] ROUND_PAR2    = 7'd60;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [63:0] BYTE_BITS    = 64'd8;

    localparam word_t H_INIT [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_ROUND [0:3] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    // Round group: selects the boolean function and the round constant.
    typedef enum logic [1:0] {
        STG_CH      = 2'd0,
        STG_PARITY1 = 2'd1,
        STG_MAJ     = 2'd2,
        STG_PARITY2 = 2'd3
    } stage_t;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        SEL_MSG  = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t sel;
        logic      count;
        logic      load;
        logic      step;
        stage_t    stage;
        logic      add;
        logic      rotate;
        logic      restart;
    } sha1_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } sha1_status_t;

endpackage

[rtl/core/sha1_datapath.sv]
// Block buffer, message schedule, round unit, chaining words and length count.
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sha1_cmd_t    cmd,
    input  logic [7:0]   data_byte,
    output sha1_status_t status,
    output logic [31:0]  digest_word
);

    word_t       chain_reg [0:NUM_CHAIN-1];
    word_t       w_reg [0:BLOCK_WORDS-1];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  pos_reg;
    logic [63:0] bit_len_reg;

    logic [7:0]  len_byte;
    logic [7:0]  push_byte;
    word_t       f_val;
    word_t       k_val;
    word_t       t_val;
    word_t       w_new;
    word_t       x_val;

    // Length bytes go out most significant first at slots 56 through 63.
    assign len_byte = bit_len_reg[{~pos_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        case (cmd.sel)
            SEL_MSG:  push_byte = data_byte;
            SEL_PAD:  push_byte = PAD_BYTE;
            SEL_LEN:  push_byte = len_byte;
            SEL_ZERO: push_byte = 8'h00;
            default:  push_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (cmd.stage)
            STG_CH:      f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            STG_MAJ:     f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            STG_PARITY1: f_val = b_reg ^ c_reg ^ d_reg;
            STG_PARITY2: f_val = b_reg ^ c_reg ^ d_reg;
            default:     f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        k_val = K_ROUND[cmd.stage];
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
        x_val = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {x_val[30:0], x_val[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                chain_reg[i] <= H_INIT[i];
            end
            pos_reg     <= '0;
            bit_len_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < NUM_CHAIN; i++)
                begin
                    chain_reg[i] <= H_INIT[i];
                end
                pos_reg     <= '0;
                bit_len_reg <= '0;
            end
            else
            begin
                if (cmd.add)
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                end
                else if (cmd.rotate)
                begin
                    for (int i = 0; i < NUM_CHAIN - 1; i++)
                    begin
                        chain_reg[i] <= chain_reg[i+1];
                    end
                    chain_reg[NUM_CHAIN-1] <= chain_reg[0];
                end
                if (cmd.push)
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
                if (cmd.count)
                begin
                    bit_len_reg <= bit_len_reg + BYTE_BITS;
                end
            end
        end
    end

    // The block buffer is a byte shift line while filling and a word shift
    // line while the schedule runs; w_reg[0] always holds the current W.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_reg[BLOCK_WORDS-1] <= {w_reg[BLOCK_WORDS-1][23:0], push_byte};
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLOCK_WORDS-1] <= w_new;
        end

        if (cmd.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.step)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign status.pos  = pos_reg;
    assign digest_word = chain_reg[0];

endmodule

[rtl/core/sha1_ctrl.sv]
// Sequencer for byte intake, padding, the 80 rounds and digest output.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         req_type,
    input  logic         out_ready,
    input  sha1_status_t status,
    output logic         in_ready,
    output logic         out_valid,
    output logic [2:0]   word_index,
    output logic         last_word,
    output sha1_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_PAD   = 3'd1,
        ST_ROUND = 3'd2,
        ST_ADD   = 3'd3,
        ST_OUT   = 3'd4
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       fin_reg, fin_next;
    logic       first_reg, first_next;
    logic       len_reg, len_next;
    logic       final_reg, final_next;
    logic       at_end;

    assign at_end = (status.pos == LAST_POS);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        len_next   = len_reg;
        final_next = final_reg;
        cmd        = '0;
        cmd.sel    = SEL_MSG;

        if (round_reg < ROUND_PAR1)
            cmd.stage = STG_CH;
        else if (round_reg < ROUND_MAJ)
            cmd.stage = STG_PARITY1;
        else if (round_reg < ROUND_PAR2)
            cmd.stage = STG_MAJ;
        else
            cmd.stage = STG_PARITY2;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!req_type)
                    begin
                        cmd.push  = 1'b1;
                        cmd.count = 1'b1;
                        cmd.load  = at_end;
                        if (at_end)
                            state_next = ST_ROUND;
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        first_next = 1'b1;
                        len_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push   = 1'b1;
                first_next = 1'b0;
                // The length starts at slot 56 of the first block in which
                // that slot comes after the 0x80 marker.
                if (first_reg)
                    cmd.sel = SEL_PAD;
                else if (len_reg || status.pos == LEN_POS)
                begin
                    cmd.sel  = SEL_LEN;
                    len_next = 1'b1;
                end
                else
                    cmd.sel = SEL_ZERO;
                if (at_end)
                begin
                    cmd.load   = 1'b1;
                    final_next = (cmd.sel == SEL_LEN);
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.step = 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
                else
                    round_next = round_reg + 7'd1;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (final_reg)
                    state_next = ST_OUT;
                else if (fin_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.rotate = 1'b1;
                    if (idx_reg == LAST_WORD_IDX)
                    begin
                        cmd.restart = 1'b1;
                        idx_next    = '0;
                        fin_next    = 1'b0;
                        len_next    = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            len_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            final_reg <= final_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == LAST_WORD_IDX);

endmodule

[rtl/core/sha1_stream_hasher.sv]
// Top level of the streaming SHA-1 hasher.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | req_type, data_byte
//  out     | output    | out_valid/out_ready | digest_word, word_index, last_word
//
// A message byte shifts into the block buffer; the 64th byte of a block also
// starts the 80 rounds in the single round unit, followed by the chaining add.
// A finish shifts in padding and length one byte a cycle, runs one or two
// compressions, then offers five digest beats.
// Input is taken only when the core is idle; the out channel stalls freely.
// Reset loads the initial chaining values at once; no clearing pass.
module sha1_stream_hasher
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1_cmd_t    cmd;
    sha1_status_t status;

    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .out_ready  (out_ready),
        .status     (status),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .word_index (word_index),
        .last_word  (last_word),
        .cmd        (cmd)
    );

    sha1_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

[rtl/core/sha1_checker.sv]
// Port-level checks on the SHA-1 hasher, bound to the top level.
module sha1_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // The core never takes input while a digest is being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while digest pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word)
            && $stable(word_index))
        else $error("stalled digest beat changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd4)) && (word_index <= 3'd4))
        else $error("bad last marker or index");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && (word_index == $past(word_index) + 3'd1))
        else $error("digest beats out of sequence");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid && in_ready)
        else $error("core not idle after last digest beat");

endmodule

bind sha1_stream_hasher sha1_checker u_sha1_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
